// ----- design/fomm_pkg.sv -----
package fomm_pkg;

   // Fixed field widths of the command and status ports.
   localparam int GAIN_WIDTH      = 16;
   localparam int RATE_WIDTH      = 16;
   localparam int ANGLE_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   // Quarter-wave sine magnitude, Q1.15 without the sign bit.
   localparam int SINE_WIDTH = 15;

   // Register indexes on the CSR port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_FRONT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_REAR  = 1'd1;

   // Taylor coefficients of sin(pi/2 * t) in Q30.
   localparam logic [63:0] COEF_A = 64'd1686629713;
   localparam logic [63:0] COEF_B = 64'd693598668;
   localparam logic [63:0] COEF_C = 64'd85569306;
   localparam logic [63:0] COEF_D = 64'd5026995;
   localparam logic [63:0] COEF_E = 64'd172272;

   localparam logic [SINE_WIDTH-1:0] SINE_MAX = {SINE_WIDTH{1'b1}};

   // Evaluates one table entry from its Q30 position t. Used only while the
   // table constants are elaborated.
   function automatic logic [SINE_WIDTH-1:0] quarter_sine(input logic [63:0] t);
      logic [63:0] s2;
      logic [63:0] acc;
      logic [63:0] v;
      s2  = (t * t) >> 30;
      acc = COEF_E;
      acc = COEF_D - ((s2 * acc) >> 30);
      acc = COEF_C - ((s2 * acc) >> 30);
      acc = COEF_B - ((s2 * acc) >> 30);
      acc = COEF_A - ((s2 * acc) >> 30);
      v   = (t * acc) >> 30;
      v   = (v + 64'd16384) >> 15;
      if (v > 64'(SINE_MAX)) begin
         v = 64'(SINE_MAX);
      end
      return v[SINE_WIDTH-1:0];
   endfunction

endpackage

// ----- design/field_oriented_mecanum_mix.sv -----
// Channel    Ports                               Handshake
// ---------  ----------------------------------  ---------------------------------
// request    req_speed_x/y, req_rotate_rate,     taken when start && !busy
//            req_heading_angle
// response   rsp_wheel_*, rsp_clipped            one cycle, marked by rsp_valid
// csr        csr_index, csr_write_data           written when csr_write_enable
//
// One request is taken every cycle; busy is never raised. Each response is
// strobed once its request has passed five registers: input register, sine
// table read, products, rounding, and wheel sum with saturation.
// Reset is synchronous and active high; it clears both gains and the stage
// valid flags. The receiver cannot stall, so the pipeline never holds.
module field_oriented_mecanum_mix #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SPEED_WIDTH      = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [SPEED_WIDTH-1:0]          req_speed_x,
   input  logic signed [SPEED_WIDTH-1:0]          req_speed_y,
   input  logic signed [fomm_pkg::RATE_WIDTH-1:0] req_rotate_rate,
   input  logic [fomm_pkg::ANGLE_WIDTH-1:0]       req_heading_angle,
   output logic                                   rsp_valid,
   output logic signed [SPEED_WIDTH-1:0]          rsp_wheel_front_a,
   output logic signed [SPEED_WIDTH-1:0]          rsp_wheel_front_b,
   output logic signed [SPEED_WIDTH-1:0]          rsp_wheel_rear_a,
   output logic signed [SPEED_WIDTH-1:0]          rsp_wheel_rear_b,
   output logic                                   rsp_clipped,
   input  logic                                   csr_write_enable,
   input  logic [fomm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fomm_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import fomm_pkg::*;

   // Each quarter turn spans the table once, so a full turn has
   // 4 * SINE_TABLE_DEPTH phase steps.
   localparam int TURN_STEPS  = 4 * SINE_TABLE_DEPTH;
   localparam int PHASE_WIDTH = $clog2(TURN_STEPS);
   localparam int ADDR_WIDTH  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int MULT_WIDTH  = ANGLE_WIDTH + PHASE_WIDTH + 1;

   localparam logic [PHASE_WIDTH:0]   TURN_STEPS_SIZED = (PHASE_WIDTH+1)'(TURN_STEPS);
   localparam logic [PHASE_WIDTH-1:0] QUARTER_1 = PHASE_WIDTH'(SINE_TABLE_DEPTH);
   localparam logic [PHASE_WIDTH-1:0] QUARTER_2 = PHASE_WIDTH'(2 * SINE_TABLE_DEPTH);
   localparam logic [PHASE_WIDTH-1:0] QUARTER_3 = PHASE_WIDTH'(3 * SINE_TABLE_DEPTH);
   localparam logic [ADDR_WIDTH-1:0]  DEPTH_ADDR = ADDR_WIDTH'(SINE_TABLE_DEPTH);

   // Signed sine/cosine carries one sign bit and one guard bit.
   localparam int TRIG_WIDTH = SINE_WIDTH + 2;
   localparam int PROD_WIDTH = SPEED_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH  = SPEED_WIDTH + 18;
   localparam int AXIS_WIDTH = SUM_WIDTH - 15;
   localparam int GPROD_WIDTH = GAIN_WIDTH + RATE_WIDTH;
   localparam int GSUM_WIDTH  = GPROD_WIDTH + 1;
   localparam int TERM_WIDTH  = GSUM_WIDTH - 12;
   localparam int WHEEL_WIDTH = ((AXIS_WIDTH > TERM_WIDTH) ? AXIS_WIDTH : TERM_WIDTH) + 2;

   localparam logic signed [SUM_WIDTH-1:0]  HALF_AXIS = SUM_WIDTH'(1 << 14);
   localparam logic signed [GSUM_WIDTH-1:0] HALF_TERM = GSUM_WIDTH'(1 << 11);
   localparam logic signed [WHEEL_WIDTH-1:0] WHEEL_HI =
      {{(WHEEL_WIDTH-SPEED_WIDTH+1){1'b0}}, {(SPEED_WIDTH-1){1'b1}}};
   localparam logic signed [WHEEL_WIDTH-1:0] WHEEL_LO = ~WHEEL_HI;

   // Configuration registers.
   logic signed [GAIN_WIDTH-1:0] gain_front_ff;
   logic signed [GAIN_WIDTH-1:0] gain_rear_ff;

   // Stage valid flags.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;

   // Stage 1: captured request.
   logic signed [SPEED_WIDTH-1:0] s1_x_ff, s1_y_ff;
   logic signed [RATE_WIDTH-1:0]  s1_rate_ff;
   logic [ANGLE_WIDTH-1:0]        s1_angle_ff;

   // Stage 1 logic: phase, quadrant and table addresses.
   logic [MULT_WIDTH-1:0]  phase_prod;
   logic [PHASE_WIDTH-1:0] phase;
   logic [1:0]             quadrant;
   logic [PHASE_WIDTH-1:0] quadrant_base;
   logic [PHASE_WIDTH-1:0] remainder;
   logic [ADDR_WIDTH-1:0]  rem_addr;
   logic [ADDR_WIDTH-1:0]  sin_addr, cos_addr;

   // Stage 2: table data comes out of the ROM registers.
   logic signed [SPEED_WIDTH-1:0] s2_x_ff, s2_y_ff;
   logic                          s2_sin_neg_ff, s2_cos_neg_ff;
   logic signed [GPROD_WIDTH-1:0] s2_front_prod_ff, s2_rear_prod_ff;
   logic signed [GPROD_WIDTH-1:0] front_prod_in, rear_prod_in;
   logic [SINE_WIDTH-1:0]         sin_mag, cos_mag;
   logic signed [TRIG_WIDTH-1:0]  sin_val, cos_val;

   // Stage 3: the four rotation products.
   logic signed [PROD_WIDTH-1:0]  ys_in, xc_in, yc_in, xs_in;
   logic signed [PROD_WIDTH-1:0]  s3_ys_ff, s3_xc_ff, s3_yc_ff, s3_xs_ff;
   logic signed [GPROD_WIDTH-1:0] s3_front_prod_ff, s3_rear_prod_ff;

   // Stage 4: rounded axis values and rotation terms.
   logic signed [SUM_WIDTH-1:0]   x_sum, y_sum;
   logic signed [GSUM_WIDTH-1:0]  front_sum, rear_sum;
   logic signed [AXIS_WIDTH-1:0]  xr_in, yr_in, s4_xr_ff, s4_yr_ff;
   logic signed [TERM_WIDTH-1:0]  front_in, rear_in, s4_front_ff, s4_rear_ff;

   // Output stage.
   logic signed [WHEEL_WIDTH-1:0] wheel_sum [4];
   logic signed [SPEED_WIDTH-1:0] wheel_in [4];
   logic signed [SPEED_WIDTH-1:0] wheel_ff [4];
   logic                          clipped_in, clipped_ff;

   logic accept;

   // Every stage advances each cycle, so a request is always welcome.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Phase = angle * 4 * depth / 65536. The quadrant comes from three
   // compares because the depth need not be a power of two. The cosine sits
   // one quadrant ahead of the sine with the same remainder, so odd quadrants
   // mirror the sine address and even ones mirror the cosine address.
   always_comb begin
      phase_prod = MULT_WIDTH'(s1_angle_ff) * MULT_WIDTH'(TURN_STEPS_SIZED);
      phase      = phase_prod[ANGLE_WIDTH +: PHASE_WIDTH];
      if (phase >= QUARTER_3) begin
         quadrant      = 2'd3;
         quadrant_base = QUARTER_3;
      end else if (phase >= QUARTER_2) begin
         quadrant      = 2'd2;
         quadrant_base = QUARTER_2;
      end else if (phase >= QUARTER_1) begin
         quadrant      = 2'd1;
         quadrant_base = QUARTER_1;
      end else begin
         quadrant      = 2'd0;
         quadrant_base = '0;
      end
      remainder = phase - quadrant_base;
      rem_addr  = remainder[ADDR_WIDTH-1:0];
      sin_addr  = quadrant[0] ? (DEPTH_ADDR - rem_addr) : rem_addr;
      cos_addr  = quadrant[0] ? rem_addr : (DEPTH_ADDR - rem_addr);
   end

   // The rotation gain products do not depend on the table, so they are
   // formed in the first stage.
   assign front_prod_in = gain_front_ff * s1_rate_ff;
   assign rear_prod_in  = gain_rear_ff * s1_rate_ff;

   fomm_sine_rom #(
      .DEPTH(SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock   (clock),
      .sin_addr(sin_addr),
      .cos_addr(cos_addr),
      .sin_data(sin_mag),
      .cos_data(cos_mag)
   );

   // Apply the quadrant signs and form the four rotation products.
   always_comb begin
      sin_val = s2_sin_neg_ff ? -$signed({2'b00, sin_mag}) : $signed({2'b00, sin_mag});
      cos_val = s2_cos_neg_ff ? -$signed({2'b00, cos_mag}) : $signed({2'b00, cos_mag});
      ys_in   = s2_y_ff * sin_val;
      xc_in   = s2_x_ff * cos_val;
      yc_in   = s2_y_ff * cos_val;
      xs_in   = s2_x_ff * sin_val;
   end

   // Round half up: add half an LSB and drop the fraction arithmetically.
   always_comb begin
      x_sum     = SUM_WIDTH'(s3_ys_ff) + SUM_WIDTH'(s3_xc_ff) + HALF_AXIS;
      y_sum     = SUM_WIDTH'(s3_yc_ff) - SUM_WIDTH'(s3_xs_ff) + HALF_AXIS;
      front_sum = GSUM_WIDTH'(s3_front_prod_ff) + HALF_TERM;
      rear_sum  = GSUM_WIDTH'(s3_rear_prod_ff) + HALF_TERM;
      xr_in     = x_sum[SUM_WIDTH-1:15];
      yr_in     = y_sum[SUM_WIDTH-1:15];
      front_in  = front_sum[GSUM_WIDTH-1:12];
      rear_in   = rear_sum[GSUM_WIDTH-1:12];
   end

   // Mecanum mix with the sign pattern ++, +-, -+, -- and saturation of each
   // wheel to the speed width. Any saturated wheel raises the clip flag.
   always_comb begin
      wheel_sum[0] = WHEEL_WIDTH'(s4_xr_ff) + WHEEL_WIDTH'(s4_yr_ff)
                   + WHEEL_WIDTH'(s4_front_ff);
      wheel_sum[1] = WHEEL_WIDTH'(s4_xr_ff) - WHEEL_WIDTH'(s4_yr_ff)
                   + WHEEL_WIDTH'(s4_front_ff);
      wheel_sum[2] = WHEEL_WIDTH'(s4_yr_ff) - WHEEL_WIDTH'(s4_xr_ff)
                   + WHEEL_WIDTH'(s4_rear_ff);
      wheel_sum[3] = -WHEEL_WIDTH'(s4_xr_ff) - WHEEL_WIDTH'(s4_yr_ff)
                   + WHEEL_WIDTH'(s4_rear_ff);
      clipped_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (wheel_sum[i] > WHEEL_HI) begin
            wheel_in[i] = WHEEL_HI[SPEED_WIDTH-1:0];
            clipped_in  = 1'b1;
         end else if (wheel_sum[i] < WHEEL_LO) begin
            wheel_in[i] = WHEEL_LO[SPEED_WIDTH-1:0];
            clipped_in  = 1'b1;
         end else begin
            wheel_in[i] = wheel_sum[i][SPEED_WIDTH-1:0];
         end
      end
   end

   // Control state: gains and stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_front_ff <= '0;
         gain_rear_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GAIN_FRONT: begin
                  gain_front_ff <= $signed(csr_write_data[GAIN_WIDTH-1:0]);
               end
               CSR_GAIN_REAR: begin
                  gain_rear_ff <= $signed(csr_write_data[GAIN_WIDTH-1:0]);
               end
               default: begin
               end
            endcase
         end
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // Payload pipeline. Only the input register is gated; later stages simply
   // follow, and their contents count only where the valid flag is set.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff     <= req_speed_x;
         s1_y_ff     <= req_speed_y;
         s1_rate_ff  <= req_rotate_rate;
         s1_angle_ff <= req_heading_angle;
      end
      s2_x_ff          <= s1_x_ff;
      s2_y_ff          <= s1_y_ff;
      s2_sin_neg_ff    <= quadrant[1];
      s2_cos_neg_ff    <= quadrant[1] ^ quadrant[0];
      s2_front_prod_ff <= front_prod_in;
      s2_rear_prod_ff  <= rear_prod_in;

      s3_ys_ff         <= ys_in;
      s3_xc_ff         <= xc_in;
      s3_yc_ff         <= yc_in;
      s3_xs_ff         <= xs_in;
      s3_front_prod_ff <= s2_front_prod_ff;
      s3_rear_prod_ff  <= s2_rear_prod_ff;

      s4_xr_ff    <= xr_in;
      s4_yr_ff    <= yr_in;
      s4_front_ff <= front_in;
      s4_rear_ff  <= rear_in;

      for (int i = 0; i < 4; i++) begin
         wheel_ff[i] <= wheel_in[i];
      end
      clipped_ff <= clipped_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_wheel_front_a = wheel_ff[0];
   assign rsp_wheel_front_b = wheel_ff[1];
   assign rsp_wheel_rear_a  = wheel_ff[2];
   assign rsp_wheel_rear_b  = wheel_ff[3];
   assign rsp_clipped       = clipped_ff;

endmodule

// ----- design/fomm_sine_rom.sv -----
module fomm_sine_rom #(
   parameter int DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic [$clog2(DEPTH+1)-1:0]           sin_addr,
   input  logic [$clog2(DEPTH+1)-1:0]           cos_addr,
   output logic [fomm_pkg::SINE_WIDTH-1:0]      sin_data,
   output logic [fomm_pkg::SINE_WIDTH-1:0]      cos_data
);
   import fomm_pkg::*;

   logic [SINE_WIDTH-1:0] rom_entry [DEPTH+1];
   logic [SINE_WIDTH-1:0] sin_data_ff;
   logic [SINE_WIDTH-1:0] cos_data_ff;

   // The table spans a quarter turn inclusive of both ends.
   for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
      localparam logic [63:0] POS = (64'(k) << 30) / DEPTH;
      assign rom_entry[k] = quarter_sine(POS);
   end

   always_ff @(posedge clock) begin
      sin_data_ff <= rom_entry[sin_addr];
      cos_data_ff <= rom_entry[cos_addr];
   end

   assign sin_data = sin_data_ff;
   assign cos_data = cos_data_ff;

endmodule
